// ----- rtl/complex_arithmetic_unit_assert.svh -----
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cau_pkg.sv -----
// Package with types, constants and codes shared by the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int ACC_W     = 2 * WORD_W + 2;
  localparam int MAG_W     = 2 * WORD_W;
  localparam int DVD_W     = MAG_W + FRAC_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_DISPLAY = 4'd2;
  localparam logic [3:0] OP_MOVE    = 4'd3;
  localparam logic [3:0] OP_CONJ    = 4'd4;
  localparam logic [3:0] OP_ADD     = 4'd5;
  localparam logic [3:0] OP_SUB     = 4'd6;
  localparam logic [3:0] OP_MUL     = 4'd7;
  localparam logic [3:0] OP_DIV     = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef enum logic [2:0] {
    MS_AC, MS_BD, MS_AD, MS_BC, MS_CC, MS_DD
  } mul_sel_t;

  typedef struct packed {
    logic [3:0]               opcode;
    logic                     slot;
    logic signed [WORD_W-1:0] real_in;
    logic signed [WORD_W-1:0] imag_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] real_out;
    logic signed [WORD_W-1:0] imag_out;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic     take;
    logic     exec;
    logic     acc_clr;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     mul_fin;
    logic     div_fin;
    logic     out_load;
  } cau_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       den_zero;
  } cau_sts_t;

endpackage
`default_nettype wire

// ----- rtl/cau_datapath.sv -----
// Datapath: operand slots, result register, shared multiplier, accumulators and divider.
`default_nettype none
module cau_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cau_pkg::cau_cmd_t   cmd,
  input  cau_pkg::in_item_t   in_data,
  output cau_pkg::cau_sts_t   sts,
  output cau_pkg::out_item_t  out_data
);
  import cau_pkg::*;

  logic [3:0]               op_r;
  logic                     sel_r;
  logic signed [WORD_W-1:0] ld_re_r, ld_im_r;
  logic signed [WORD_W-1:0] slot_re_r [2];
  logic signed [WORD_W-1:0] slot_im_r [2];
  logic signed [WORD_W-1:0] res_re_r, res_im_r;
  logic signed [MAG_W-1:0]  p_r;
  mul_sel_t                 p_sel_r;
  logic                     p_vld_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r, acc_den_r;
  logic [DVD_W-1:0]         dvd_re_r, dvd_im_r;
  logic [MAG_W-1:0]         rem_re_r, rem_im_r;
  logic [WORD_W:0]          q_re_r, q_im_r;
  logic                     ov_re_r, ov_im_r, neg_re_r, neg_im_r;
  logic signed [WORD_W-1:0] show_re_r, show_im_r;
  logic [1:0]               show_st_r;
  out_item_t                out_r;

  logic signed [WORD_W-1:0] mx, my;
  logic signed [MAG_W-1:0]  prod;
  logic signed [ACC_W-1:0]  p_ext;
  logic [MAG_W-1:0]         den;
  logic [MAG_W:0]           rsh_re, rsh_im, dif_re, dif_im;
  logic                     ge_re, ge_im;
  logic signed [ACC_W-1:0]  mag_re, mag_im;

  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};

  function automatic logic [WORD_W:0] sat_w(input logic signed [ACC_W-1:0] v);
    logic [WORD_W:0] r;
    if (v > ACC_W'(WMAX)) begin
      r = {1'b1, WMAX};
    end else if (v < ACC_W'(WMIN)) begin
      r = {1'b1, WMIN};
    end else begin
      r = {1'b0, v[WORD_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [WORD_W:0] div_out(input logic [WORD_W:0] q, input logic ov,
                                              input logic neg);
    logic [WORD_W:0] lim;
    logic [WORD_W:0] qq;
    logic            s;
    lim = neg ? {2'b01, {(WORD_W-1){1'b0}}} : {2'b00, {(WORD_W-1){1'b1}}};
    s   = ov || (q > lim);
    qq  = s ? lim : q;
    qq  = neg ? (~qq + 1'b1) : qq;
    return {s, qq[WORD_W-1:0]};
  endfunction

  always_comb begin
    case (cmd.mul_sel)
      MS_AC:   begin mx = slot_re_r[1]; my = slot_re_r[0]; end
      MS_BD:   begin mx = slot_im_r[1]; my = slot_im_r[0]; end
      MS_AD:   begin mx = slot_re_r[1]; my = slot_im_r[0]; end
      MS_BC:   begin mx = slot_im_r[1]; my = slot_re_r[0]; end
      MS_CC:   begin mx = slot_re_r[0]; my = slot_re_r[0]; end
      MS_DD:   begin mx = slot_im_r[0]; my = slot_im_r[0]; end
      default: begin mx = slot_re_r[0]; my = slot_re_r[0]; end
    endcase
  end

  assign prod   = mx * my;
  assign p_ext  = ACC_W'(p_r);
  assign den    = acc_den_r[MAG_W-1:0];
  assign rsh_re = {rem_re_r, dvd_re_r[DVD_W-1]};
  assign rsh_im = {rem_im_r, dvd_im_r[DVD_W-1]};
  assign ge_re  = rsh_re >= {1'b0, den};
  assign ge_im  = rsh_im >= {1'b0, den};
  assign dif_re = rsh_re - {1'b0, den};
  assign dif_im = rsh_im - {1'b0, den};
  assign mag_re = acc_re_r[ACC_W-1] ? -acc_re_r : acc_re_r;
  assign mag_im = acc_im_r[ACC_W-1] ? -acc_im_r : acc_im_r;

  assign sts.op       = op_r;
  assign sts.den_zero = (acc_den_r == '0);
  assign out_data     = out_r;

  always_ff @(posedge clk) begin
    logic [WORD_W:0] t_re, t_im;
    logic signed [WORD_W:0] s_re, s_im;
    if (!rst_n) begin
      slot_re_r[0] <= '0;
      slot_re_r[1] <= '0;
      slot_im_r[0] <= '0;
      slot_im_r[1] <= '0;
      res_re_r     <= '0;
      res_im_r     <= '0;
      p_vld_r      <= 1'b0;
    end else begin
      if (cmd.take) begin
        op_r    <= in_data.opcode;
        sel_r   <= in_data.slot;
        ld_re_r <= in_data.real_in;
        ld_im_r <= in_data.imag_in;
      end

      if (cmd.exec) begin
        case (op_r)
          OP_NONE, OP_MUL, OP_DIV: begin
          end
          OP_LOAD: begin
            slot_re_r[sel_r] <= ld_re_r;
            slot_im_r[sel_r] <= ld_im_r;
          end
          OP_DISPLAY: begin
            show_re_r <= slot_re_r[sel_r];
            show_im_r <= slot_im_r[sel_r];
            show_st_r <= ST_OK;
          end
          OP_MOVE: begin
            slot_re_r[sel_r] <= res_re_r;
            slot_im_r[sel_r] <= res_im_r;
            show_re_r        <= res_re_r;
            show_im_r        <= res_im_r;
            show_st_r        <= ST_OK;
          end
          OP_CONJ: begin
            show_re_r <= slot_re_r[sel_r];
            if (slot_im_r[sel_r] == WMIN) begin
              slot_im_r[sel_r] <= WMAX;
              show_im_r        <= WMAX;
              show_st_r        <= ST_SAT;
            end else begin
              slot_im_r[sel_r] <= -slot_im_r[sel_r];
              show_im_r        <= -slot_im_r[sel_r];
              show_st_r        <= ST_OK;
            end
          end
          OP_ADD, OP_SUB: begin
            if (op_r == OP_ADD) begin
              s_re = (WORD_W+1)'(slot_re_r[1]) + (WORD_W+1)'(slot_re_r[0]);
              s_im = (WORD_W+1)'(slot_im_r[1]) + (WORD_W+1)'(slot_im_r[0]);
            end else begin
              s_re = (WORD_W+1)'(slot_re_r[1]) - (WORD_W+1)'(slot_re_r[0]);
              s_im = (WORD_W+1)'(slot_im_r[1]) - (WORD_W+1)'(slot_im_r[0]);
            end
            t_re = sat_w(ACC_W'(s_re));
            t_im = sat_w(ACC_W'(s_im));
            res_re_r  <= t_re[WORD_W-1:0];
            res_im_r  <= t_im[WORD_W-1:0];
            show_re_r <= t_re[WORD_W-1:0];
            show_im_r <= t_im[WORD_W-1:0];
            show_st_r <= (t_re[WORD_W] || t_im[WORD_W]) ? ST_SAT : ST_OK;
          end
          default: begin
            show_re_r <= '0;
            show_im_r <= '0;
            show_st_r <= ST_BAD;
          end
        endcase
      end

      p_vld_r <= cmd.mul_go;
      if (cmd.mul_go) begin
        p_r     <= prod;
        p_sel_r <= cmd.mul_sel;
      end

      if (cmd.acc_clr) begin
        acc_re_r  <= '0;
        acc_im_r  <= '0;
        acc_den_r <= '0;
      end else if (p_vld_r) begin
        case (p_sel_r)
          MS_AC:   acc_re_r <= acc_re_r + p_ext;
          MS_BD:   acc_re_r <= (op_r == OP_DIV) ? acc_re_r + p_ext : acc_re_r - p_ext;
          MS_AD:   acc_im_r <= (op_r == OP_DIV) ? acc_im_r - p_ext : acc_im_r + p_ext;
          MS_BC:   acc_im_r <= acc_im_r + p_ext;
          default: acc_den_r <= acc_den_r + p_ext;
        endcase
      end

      if (cmd.div_init) begin
        dvd_re_r <= {mag_re[MAG_W-1:0], {FRAC_W{1'b0}}};
        dvd_im_r <= {mag_im[MAG_W-1:0], {FRAC_W{1'b0}}};
        rem_re_r <= '0;
        rem_im_r <= '0;
        q_re_r   <= '0;
        q_im_r   <= '0;
        ov_re_r  <= 1'b0;
        ov_im_r  <= 1'b0;
        neg_re_r <= acc_re_r[ACC_W-1];
        neg_im_r <= acc_im_r[ACC_W-1];
      end else if (cmd.div_step) begin
        dvd_re_r <= {dvd_re_r[DVD_W-2:0], 1'b0};
        dvd_im_r <= {dvd_im_r[DVD_W-2:0], 1'b0};
        rem_re_r <= ge_re ? dif_re[MAG_W-1:0] : rsh_re[MAG_W-1:0];
        rem_im_r <= ge_im ? dif_im[MAG_W-1:0] : rsh_im[MAG_W-1:0];
        q_re_r   <= {q_re_r[WORD_W-1:0], ge_re};
        q_im_r   <= {q_im_r[WORD_W-1:0], ge_im};
        ov_re_r  <= ov_re_r | q_re_r[WORD_W];
        ov_im_r  <= ov_im_r | q_im_r[WORD_W];
      end

      if (cmd.mul_fin) begin
        t_re = sat_w(acc_re_r >>> FRAC_W);
        t_im = sat_w(acc_im_r >>> FRAC_W);
        res_re_r  <= t_re[WORD_W-1:0];
        res_im_r  <= t_im[WORD_W-1:0];
        show_re_r <= t_re[WORD_W-1:0];
        show_im_r <= t_im[WORD_W-1:0];
        show_st_r <= (t_re[WORD_W] || t_im[WORD_W]) ? ST_SAT : ST_OK;
      end

      if (cmd.div_fin) begin
        if (acc_den_r == '0) begin
          res_re_r  <= '0;
          res_im_r  <= '0;
          show_re_r <= '0;
          show_im_r <= '0;
          show_st_r <= ST_DIV0;
        end else begin
          t_re = div_out(q_re_r, ov_re_r, neg_re_r);
          t_im = div_out(q_im_r, ov_im_r, neg_im_r);
          res_re_r  <= t_re[WORD_W-1:0];
          res_im_r  <= t_im[WORD_W-1:0];
          show_re_r <= t_re[WORD_W-1:0];
          show_im_r <= t_im[WORD_W-1:0];
          show_st_r <= (t_re[WORD_W] || t_im[WORD_W]) ? ST_SAT : ST_OK;
        end
      end

      if (cmd.out_load) begin
        out_r.real_out <= show_re_r;
        out_r.imag_out <= show_im_r;
        out_r.status   <= show_st_r;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cau_controller.sv -----
// Controller: sequences decode, multiplier issue, division steps and result hand-off.
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module cau_controller (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  cau_pkg::cau_sts_t  sts,
  output cau_pkg::cau_cmd_t  cmd
);
  import cau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MUL, S_DRAIN, S_CHK, S_DIV, S_MFIN, S_DFIN, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             is_div, last_mul;

  assign is_div    = (sts.op == OP_DIV);
  assign last_mul  = is_div ? (cnt_r == CNT_W'(5)) : (cnt_r == CNT_W'(3));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MS_AC;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.exec    = 1'b1;
        cmd.acc_clr = 1'b1;
        cnt_nxt     = '0;
        case (sts.op)
          OP_NONE, OP_LOAD: state_nxt = S_IDLE;
          OP_MUL, OP_DIV:   state_nxt = S_MUL;
          default:          state_nxt = S_OUT;
        endcase
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        case (cnt_r[2:0])
          3'd0:    cmd.mul_sel = MS_AC;
          3'd1:    cmd.mul_sel = MS_BD;
          3'd2:    cmd.mul_sel = MS_AD;
          3'd3:    cmd.mul_sel = MS_BC;
          3'd4:    cmd.mul_sel = MS_CC;
          default: cmd.mul_sel = MS_DD;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (last_mul) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = is_div ? S_CHK : S_MFIN;
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (sts.den_zero) begin
          state_nxt = S_DFIN;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DFIN;
        end
      end
      S_MFIN: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_OUT;
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CAU_ASSERT(a_take_decodes, (in_valid && in_ready) |=> (state_r == S_DEC), "item not decoded")
  `CAU_ASSERT(a_div_bound, (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)), "divide overrun")
  `CAU_ASSERT(a_div_ends, (state_r == S_DIV && cnt_r == CNT_W'(DIV_STEPS - 1)) |=> (state_r == S_DFIN), "divide end missed")
  `CAU_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset not idle")

endmodule
`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// Top level of the complex arithmetic unit: controller plus datapath.
// Load and no-op end in decode with no result; display, move, conjugate, add and subtract go from decode to the output.
// Multiply forms four products through one 32x32 multiplier, then scales them down and saturates.
// Divide forms six products, then runs 80 restoring steps; a zero divisor skips the steps.
// One item at a time; a new item is taken while a result waits at the output register.
// Synchronous active-low reset clears the slots, the result register and all control.
`default_nettype none
module complex_arithmetic_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cau_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output cau_pkg::out_item_t  out_data
);
  import cau_pkg::*;

  cau_cmd_t cmd;
  cau_sts_t sts;

  cau_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cau_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- test/tb_complex_arithmetic_unit.sv -----
// Self-checking testbench for the complex arithmetic unit: predicts every result and checks it.
`default_nettype none
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  class cau_scoreboard;
    logic signed [WORD_W-1:0] slot_re[2];
    logic signed [WORD_W-1:0] slot_im[2];
    logic signed [WORD_W-1:0] res_re;
    logic signed [WORD_W-1:0] res_im;
    out_item_t pending[$];
    int errors;

    function new();
      slot_re[0] = 0; slot_re[1] = 0; slot_im[0] = 0; slot_im[1] = 0;
      res_re = 0; res_im = 0; errors = 0;
    endfunction

    // Floor shift by sh, then clamp to the word.
    function logic signed [WORD_W-1:0] clamp(logic signed [127:0] v, int sh, ref bit sat);
      logic signed [127:0] q;
      q = v >>> sh;
      if (q > 128'sh7fffffff) begin
        sat = 1; return 32'sh7fffffff;
      end
      if (q < -128'sh80000000) begin
        sat = 1; return 32'sh80000000;
      end
      return q[WORD_W-1:0];
    endfunction

    // Quotient with FRAC_W fraction bits, truncated toward zero, then clamped.
    function logic signed [WORD_W-1:0] quot(logic signed [127:0] n, logic [127:0] den,
                                            ref bit sat);
      logic [127:0] mag;
      logic [127:0] q;
      bit neg;
      neg = n < 0;
      mag = neg ? -n : n;
      q = (mag << FRAC_W) / den;
      if (!neg && q > 128'h7fffffff) begin
        sat = 1; return 32'sh7fffffff;
      end
      if (neg && q > 128'h80000000) begin
        sat = 1; return 32'sh80000000;
      end
      return neg ? -q[WORD_W-1:0] : q[WORD_W-1:0];
    endfunction

    function void note_item(in_item_t it);
      logic signed [127:0] a, b, c, d;
      logic [127:0] den;
      bit sat;
      out_item_t r;
      a = slot_re[1]; b = slot_im[1]; c = slot_re[0]; d = slot_im[0];
      sat = 0;
      r.status = ST_OK;
      case (it.opcode)
        OP_NONE: return;
        OP_LOAD: begin
          slot_re[it.slot] = it.real_in;
          slot_im[it.slot] = it.imag_in;
          return;
        end
        OP_DISPLAY: begin
          r.real_out = slot_re[it.slot]; r.imag_out = slot_im[it.slot];
        end
        OP_MOVE: begin
          slot_re[it.slot] = res_re; slot_im[it.slot] = res_im;
          r.real_out = res_re; r.imag_out = res_im;
        end
        OP_CONJ: begin
          slot_im[it.slot] = clamp(-$signed(128'(slot_im[it.slot])), 0, sat);
          r.real_out = slot_re[it.slot]; r.imag_out = slot_im[it.slot];
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (it.opcode == OP_ADD) begin
            res_re = clamp(a + c, 0, sat); res_im = clamp(b + d, 0, sat);
          end else if (it.opcode == OP_SUB) begin
            res_re = clamp(a - c, 0, sat); res_im = clamp(b - d, 0, sat);
          end else if (it.opcode == OP_MUL) begin
            res_re = clamp(a * c - b * d, FRAC_W, sat);
            res_im = clamp(a * d + b * c, FRAC_W, sat);
          end else begin
            den = c * c + d * d;
            if (den == 0) begin
              res_re = 0; res_im = 0; r.status = ST_DIV0;
            end else begin
              res_re = quot(a * c + b * d, den, sat);
              res_im = quot(b * c - a * d, den, sat);
            end
          end
          r.real_out = res_re; r.imag_out = res_im;
        end
        default: begin
          r.real_out = 0; r.imag_out = 0; r.status = ST_BAD;
        end
      endcase
      if (sat) r.status = ST_SAT;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got); errors++; return;
      end
      want = pending.pop_front();
      if (got.real_out !== want.real_out) begin
        $error("real_out: expected %h, got %h", want.real_out, got.real_out); errors++;
      end
      if (got.imag_out !== want.imag_out) begin
        $error("imag_out: expected %h, got %h", want.imag_out, got.imag_out); errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  cau_scoreboard board = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  int tick = 0;

  complex_arithmetic_unit dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    tick <= tick + 1;
    if (rst_n) begin
      if (in_valid && in_ready) board.note_item(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("FAIL complex_arithmetic_unit");
        $finish;
      end
      if (tick % 300 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((tick / 7) % 3 != 0);
      endcase
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
      4: return $urandom_range(0, 32'h3ffffff) - 32'h1ffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [3:0] op, logic sl, logic [31:0] re, logic [31:0] im);
    in_item_t it;
    it.opcode = op; it.slot = sl; it.real_in = re; it.imag_in = im;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  initial begin
    int burst;
    logic [3:0] op;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(OP_DIV, 0, 0, 0);
    send(OP_NONE, 0, 0, 0);
    send(OP_LOAD, 1, 32'h7fffffff, 32'h80000000);
    send(OP_LOAD, 0, 32'h7fffffff, 32'h80000000);
    send(OP_DISPLAY, 1, 0, 0);
    send(OP_ADD, 0, 0, 0);
    send(OP_SUB, 0, 0, 0);
    send(OP_MUL, 0, 0, 0);
    send(OP_DIV, 0, 0, 0);
    send(OP_MOVE, 0, 0, 0);
    send(OP_CONJ, 1, 0, 0);
    send(OP_CONJ, 1, 0, 0);
    send(OP_LOAD, 0, 32'h00000001, 32'h0);
    send(OP_DIV, 0, 0, 0);
    send(OP_LOAD, 0, 32'hffffffff, 32'hffffffff);
    send(OP_MUL, 0, 0, 0);
    send(OP_DIV, 0, 0, 0);
    send(OP_SUB, 0, 0, 0);
    send(OP_LOAD, 0, 0, 32'h00010000);
    send(OP_DIV, 0, 0, 0);
    send(OP_MOVE, 1, 0, 0);
    send(4'd9, 0, 0, 0);
    send(4'd15, 1, 32'hffffffff, 32'hffffffff);
    for (int n = 0; n < 1550; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: op = OP_LOAD;
          5: op = OP_DISPLAY;
          6: op = OP_MOVE;
          7: op = OP_CONJ;
          8, 9: op = OP_ADD;
          10, 11: op = OP_SUB;
          12, 13, 14: op = OP_MUL;
          15, 16: op = OP_DIV;
          17: op = OP_NONE;
          default: op = 4'($urandom_range(0, 15));
        endcase
        send(op, 1'($urandom_range(0, 1)), pick_word(), pick_word());
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS complex_arithmetic_unit");
    end else begin
      $display("FAIL complex_arithmetic_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- complex_arithmetic_unit.f -----
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_datapath.sv
rtl/cau_controller.sv
rtl/complex_arithmetic_unit.sv
test/tb_complex_arithmetic_unit.sv
